FILE: rtl/core/pltw_pkg.sv
// Shared types and constants for the progenitor link and tree walk block.
// No dependencies; the other files of the block, apart from pltw_ram, refer to it by scoped names.
package pltw_pkg;

  localparam int MODE_W        = 2;
  localparam int IDX_W         = 10;
  localparam int LINK_W        = 11;
  localparam int SIZE_W        = 31;
  localparam int CNT_W         = 11;
  localparam int EPOCH_W       = 8;
  localparam int DEF_MAX_HALOS = 1024;

  localparam logic [CNT_W-1:0]  HALO_COUNT_RST = 11'd1024;
  localparam logic [LINK_W-1:0] LINK_NONE      = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_START   = 2'd2,
    MODE_ADVANCE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_DESC_DROP = 3'd1,
    ST_HEAD_SKIP = 3'd2,
    ST_ROOT_SKIP = 3'd3,
    ST_VISIT     = 3'd4,
    ST_FINISH    = 3'd5,
    ST_ABORT     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_VISIT     = 2'd0,
    PH_PROG_INIT = 2'd1,
    PH_PROG      = 2'd2,
    PH_GROUP     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LINK_W-1:0] desc;
    logic [SIZE_W-1:0] size;
    logic [LINK_W-1:0] ghead;
    logic [LINK_W-1:0] glink;
  } rec_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  vidx;
    logic [IDX_W-1:0]  vnum;
    logic [CNT_W-1:0]  tsize;
  } res_t;

endpackage

FILE: rtl/core/progenitor_link_and_tree_walk.sv
// Top level of the progenitor link and tree walk block: sequencer, table memories, output.
// Depends on pltw_pkg, pltw_ram and pltw_out_buf.
//
// The block holds up to MAX_HALOS halo records in six one-port-read RAMs and answers each
// input transaction with exactly one result transaction. After reset a sweep initializes
// the progenitor heads and the mark memories; no input is taken during it. A load reads
// the head, reads the head's size and splices the list. Visited and group-done marks are
// epoch tagged, so a clear only bumps the epoch, and once every 255 clears the epoch wraps
// and the marks are swept again. An advance runs the walk until the next visit or its end,
// visiting entries, scanning progenitor and group entries, looking up groups and popping
// frames off the walk stack. The walk stack lives in RAM with the top frame held in
// registers. The next input is accepted while the previous result still waits in the
// output register.
module progenitor_link_and_tree_walk #(
  parameter int MAX_HALOS = pltw_pkg::DEF_MAX_HALOS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pltw_pkg::MODE_W-1:0]   in_mode,
  input  logic [pltw_pkg::IDX_W-1:0]    in_halo_index,
  input  logic signed [pltw_pkg::LINK_W-1:0] in_descendant,
  input  logic [pltw_pkg::SIZE_W-1:0]   in_particle_count,
  input  logic signed [pltw_pkg::LINK_W-1:0] in_group_first,
  input  logic signed [pltw_pkg::LINK_W-1:0] in_group_next,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [pltw_pkg::IDX_W-1:0]    out_visited_index,
  output logic [pltw_pkg::IDX_W-1:0]    out_visit_number,
  output logic [pltw_pkg::CNT_W-1:0]    out_tree_size,
  // configuration
  input  logic                          cfg_we,
  input  logic [pltw_pkg::CNT_W-1:0]    cfg_wdata
);

  localparam int AW   = $clog2(MAX_HALOS);
  localparam int LW   = pltw_pkg::LINK_W;
  localparam int CW   = pltw_pkg::CNT_W;
  localparam int EW   = pltw_pkg::EPOCH_W;
  localparam int FR_W = AW + 2 + LW;
  localparam int RECW = $bits(pltw_pkg::rec_t);
  localparam logic [AW-1:0] SW_LAST = AW'(MAX_HALOS - 1);

  typedef enum logic [18:0] {
    S_SWEEP  = 19'b000_0000_0000_0000_0001,
    S_IDLE   = 19'b000_0000_0000_0000_0010,
    S_LD0    = 19'b000_0000_0000_0000_0100,
    S_LD1    = 19'b000_0000_0000_0000_1000,
    S_LD2    = 19'b000_0000_0000_0001_0000,
    S_LD3    = 19'b000_0000_0000_0010_0000,
    S_LD4    = 19'b000_0000_0000_0100_0000,
    S_ST0    = 19'b000_0000_0000_1000_0000,
    S_ST1    = 19'b000_0000_0001_0000_0000,
    S_WTOP   = 19'b000_0000_0010_0000_0000,
    S_WV1    = 19'b000_0000_0100_0000_0000,
    S_WV2    = 19'b000_0000_1000_0000_0000,
    S_WP1    = 19'b000_0001_0000_0000_0000,
    S_WSCAN  = 19'b000_0010_0000_0000_0000,
    S_WSCAN2 = 19'b000_0100_0000_0000_0000,
    S_WG1    = 19'b000_1000_0000_0000_0000,
    S_WG2    = 19'b001_0000_0000_0000_0000,
    S_WPOP   = 19'b010_0000_0000_0000_0000,
    S_DONE   = 19'b100_0000_0000_0000_0000
  } state_t;

  function automatic logic in_range(input logic [LW-1:0] v, input logic [CW-1:0] lim);
    return !v[LW-1] && (v < lim);
  endfunction

  function automatic logic [AW-1:0] adr(input logic [LW-1:0] v);
    return AW'(v);
  endfunction

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     halo_count_r;
  logic [EW-1:0]     epoch_r, epoch_nxt;
  logic              sweep_all_r, sweep_all_nxt;
  logic              sweep_clr_r, sweep_clr_nxt;
  logic [AW-1:0]     sw_r, sw_nxt;
  logic              active_r, active_nxt;
  logic [CW-1:0]     sp_r, sp_nxt;
  logic [CW-1:0]     vc_r, vc_nxt;

  // payload state
  logic [pltw_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [LW-1:0]               desc_r, desc_nxt;
  logic [pltw_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [LW-1:0]               gfirst_r, gfirst_nxt;
  logic [LW-1:0]               gnext_r, gnext_nxt;
  logic [LW-1:0]               h_r, h_nxt;
  logic [LW-1:0]               d_r, d_nxt;
  logic [LW-1:0]               g_r, g_nxt;
  logic [LW-1:0]               p_r, p_nxt;
  logic [CW-1:0]               steps_r, steps_nxt;
  logic [AW-1:0]               node_r, node_nxt;
  pltw_pkg::phase_t            phase_r, phase_nxt;
  logic [LW-1:0]               ptr_r, ptr_nxt;
  pltw_pkg::status_t           st_r, st_nxt;
  logic [pltw_pkg::IDX_W-1:0]  vidx_r, vidx_nxt;
  logic [pltw_pkg::IDX_W-1:0]  vnum_r, vnum_nxt;

  // memory ports
  pltw_pkg::rec_t    rec_rd, rec_wd;
  logic              rec_we;
  logic [AW-1:0]     rec_wa, rec_ra;
  logic [LW-1:0]     pn_rd, pn_wd;
  logic              pn_we;
  logic [AW-1:0]     pn_wa, pn_ra;
  logic [LW-1:0]     ph_rd, ph_wd;
  logic              ph_we;
  logic [AW-1:0]     ph_wa, ph_ra;
  logic [EW-1:0]     vis_rd, vis_wd;
  logic              vis_we;
  logic [AW-1:0]     vis_wa, vis_ra;
  logic [EW-1:0]     gd_rd, gd_wd;
  logic              gd_we;
  logic [AW-1:0]     gd_wa, gd_ra;
  logic [FR_W-1:0]   stk_rd, stk_wd;
  logic              stk_we;
  logic [AW-1:0]     stk_wa, stk_ra;
  logic [RECW-1:0]   rec_rd_raw;

  logic              in_acc;
  logic [CW-1:0]     n_w;
  logic [LW-1:0]     idx_link;
  logic [LW-1:0]     nx_w;
  logic              res_ready;
  pltw_pkg::res_t    res_w, res_q;

  assign rec_rd   = pltw_pkg::rec_t'(rec_rd_raw);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // effective entry count: halo_count capped by the table depth
  assign n_w      = (32'(halo_count_r) > MAX_HALOS) ? CW'(MAX_HALOS) : halo_count_r;
  assign idx_link = LW'(idx_r);
  assign nx_w     = (phase_r == pltw_pkg::PH_PROG) ? pn_rd : rec_rd.glink;

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    sweep_all_nxt = sweep_all_r;
    sweep_clr_nxt = sweep_clr_r;
    sw_nxt        = sw_r;
    active_nxt    = active_r;
    sp_nxt        = sp_r;
    vc_nxt        = vc_r;
    idx_nxt       = idx_r;
    desc_nxt      = desc_r;
    size_nxt      = size_r;
    gfirst_nxt    = gfirst_r;
    gnext_nxt     = gnext_r;
    h_nxt         = h_r;
    d_nxt         = d_r;
    g_nxt         = g_r;
    p_nxt         = p_r;
    steps_nxt     = steps_r;
    node_nxt      = node_r;
    phase_nxt     = phase_r;
    ptr_nxt       = ptr_r;
    st_nxt        = st_r;
    vidx_nxt      = vidx_r;
    vnum_nxt      = vnum_r;

    rec_we = 1'b0;  rec_wa = '0;  rec_wd = '0;  rec_ra = '0;
    pn_we  = 1'b0;  pn_wa  = '0;  pn_wd  = '0;  pn_ra  = '0;
    ph_we  = 1'b0;  ph_wa  = '0;  ph_wd  = '0;  ph_ra  = '0;
    vis_we = 1'b0;  vis_wa = '0;  vis_wd = '0;  vis_ra = '0;
    gd_we  = 1'b0;  gd_wa  = '0;  gd_wd  = '0;  gd_ra  = '0;
    stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = '0;

    unique case (state_r)
      S_SWEEP: begin
        // one entry per cycle: heads to none (reset only), marks to the zero epoch
        ph_we  = sweep_all_r;
        ph_wa  = sw_r;
        ph_wd  = pltw_pkg::LINK_NONE;
        vis_we = 1'b1;
        vis_wa = sw_r;
        gd_we  = 1'b1;
        gd_wa  = sw_r;
        sw_nxt = sw_r + AW'(1);
        if (sw_r == SW_LAST) begin
          epoch_nxt     = EW'(1);
          sweep_all_nxt = 1'b0;
          sw_nxt        = '0;
          state_nxt     = sweep_clr_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          idx_nxt    = in_halo_index;
          desc_nxt   = in_descendant;
          size_nxt   = in_particle_count;
          gfirst_nxt = in_group_first;
          gnext_nxt  = in_group_next;
          st_nxt     = pltw_pkg::ST_DONE;
          vidx_nxt   = '0;
          vnum_nxt   = '0;
          unique case (pltw_pkg::mode_t'(in_mode))
            pltw_pkg::MODE_LOAD: state_nxt = S_LD0;
            pltw_pkg::MODE_CLEAR: begin
              // bump the epoch; sweep only when it would wrap
              if (epoch_r == '1) begin
                sweep_clr_nxt = 1'b1;
                sw_nxt        = '0;
                state_nxt     = S_SWEEP;
              end else begin
                epoch_nxt = epoch_r + EW'(1);
                state_nxt = S_DONE;
              end
            end
            pltw_pkg::MODE_START: begin
              active_nxt = 1'b0;
              if (CW'(in_halo_index) >= n_w) begin
                st_nxt    = pltw_pkg::ST_ROOT_SKIP;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ST0;
              end
            end
            pltw_pkg::MODE_ADVANCE: begin
              if (!active_r) begin
                st_nxt    = pltw_pkg::ST_FINISH;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_WTOP;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // ---------------------------------------------------------------- load
      S_LD0: begin
        if (CW'(idx_r) >= n_w) begin
          state_nxt = S_DONE;
        end else begin
          rec_we       = 1'b1;
          rec_wa       = adr(idx_link);
          rec_wd.size  = size_r;
          rec_wd.ghead = gfirst_r;
          rec_wd.glink = gnext_r;
          rec_wd.desc  = in_range(desc_r, n_w) ? desc_r : pltw_pkg::LINK_NONE;
          pn_we        = 1'b1;
          pn_wa        = adr(idx_link);
          pn_wd        = pltw_pkg::LINK_NONE;
          if (desc_r[LW-1]) begin
            state_nxt = S_DONE;
          end else if (!in_range(desc_r, n_w)) begin
            st_nxt    = pltw_pkg::ST_DESC_DROP;
            state_nxt = S_DONE;
          end else begin
            ph_ra     = adr(desc_r);
            state_nxt = S_LD1;
          end
        end
      end

      S_LD1: begin
        h_nxt = ph_rd;
        if (ph_rd[LW-1]) begin
          ph_we     = 1'b1;
          ph_wa     = adr(desc_r);
          ph_wd     = idx_link;
          state_nxt = S_DONE;
        end else if (!in_range(ph_rd, n_w)) begin
          st_nxt    = pltw_pkg::ST_HEAD_SKIP;
          state_nxt = S_DONE;
        end else begin
          rec_ra    = adr(ph_rd);
          state_nxt = S_LD2;
        end
      end

      S_LD2: begin
        if (size_r >= rec_rd.size) begin
          // new entry takes over the head
          pn_we     = 1'b1;
          pn_wa     = adr(idx_link);
          pn_wd     = h_r;
          ph_we     = 1'b1;
          ph_wa     = adr(desc_r);
          ph_wd     = idx_link;
          state_nxt = S_DONE;
        end else begin
          pn_ra     = adr(h_r);
          state_nxt = S_LD3;
        end
      end

      S_LD3: begin
        pn_we     = 1'b1;
        pn_wa     = adr(idx_link);
        pn_wd     = pn_rd;
        state_nxt = S_LD4;
      end

      S_LD4: begin
        pn_we     = 1'b1;
        pn_wa     = adr(h_r);
        pn_wd     = idx_link;
        state_nxt = S_DONE;
      end

      // ---------------------------------------------------------------- start
      S_ST0: begin
        rec_ra    = adr(idx_link);
        vis_ra    = adr(idx_link);
        state_nxt = S_ST1;
      end

      S_ST1: begin
        if ((vis_rd == epoch_r) || rec_rd.ghead[LW-1]) begin
          st_nxt = pltw_pkg::ST_ROOT_SKIP;
        end else begin
          vc_nxt     = '0;
          active_nxt = 1'b1;
          sp_nxt     = '0;
          node_nxt   = adr(idx_link);
          phase_nxt  = pltw_pkg::PH_VISIT;
          ptr_nxt    = pltw_pkg::LINK_NONE;
        end
        state_nxt = S_DONE;
      end

      // ---------------------------------------------------------------- walk
      S_WTOP: begin
        if (sp_r >= n_w) begin
          active_nxt = 1'b0;
          st_nxt     = pltw_pkg::ST_ABORT;
          state_nxt  = S_DONE;
        end else begin
          case (phase_r)
            pltw_pkg::PH_VISIT: begin
              if (vc_r >= n_w) begin
                active_nxt = 1'b0;
                st_nxt     = pltw_pkg::ST_ABORT;
                state_nxt  = S_DONE;
              end else begin
                vis_we    = 1'b1;
                vis_wa    = node_r;
                vis_wd    = epoch_r;
                rec_ra    = node_r;
                state_nxt = S_WV1;
              end
            end
            pltw_pkg::PH_PROG_INIT: begin
              ph_ra     = node_r;
              state_nxt = S_WP1;
            end
            default: begin
              // progenitor or group list: restart the scan from the saved pointer
              p_nxt     = ptr_r;
              steps_nxt = '0;
              state_nxt = S_WSCAN;
            end
          endcase
        end
      end

      S_WV1: begin
        vidx_nxt  = pltw_pkg::IDX_W'(node_r);
        vnum_nxt  = pltw_pkg::IDX_W'(vc_r);
        vc_nxt    = vc_r + CW'(1);
        phase_nxt = pltw_pkg::PH_PROG_INIT;
        d_nxt     = rec_rd.desc;
        if (rec_rd.desc[LW-1]) begin
          st_nxt    = pltw_pkg::ST_VISIT;
          state_nxt = S_DONE;
        end else if (!in_range(rec_rd.desc, n_w)) begin
          active_nxt = 1'b0;
          st_nxt     = pltw_pkg::ST_ABORT;
          state_nxt  = S_DONE;
        end else begin
          vis_ra    = adr(rec_rd.desc);
          state_nxt = S_WV2;
        end
      end

      S_WV2: begin
        state_nxt = S_DONE;
        if (vis_rd == epoch_r) begin
          st_nxt = pltw_pkg::ST_VISIT;
        end else if (sp_r + CW'(1) >= n_w) begin
          active_nxt = 1'b0;
          st_nxt     = pltw_pkg::ST_ABORT;
        end else begin
          // push the descendant on top
          stk_we    = 1'b1;
          stk_wa    = adr(sp_r);
          stk_wd    = {node_r, phase_r, ptr_r};
          node_nxt  = adr(d_r);
          phase_nxt = pltw_pkg::PH_VISIT;
          ptr_nxt   = pltw_pkg::LINK_NONE;
          sp_nxt    = sp_r + CW'(1);
          st_nxt    = pltw_pkg::ST_VISIT;
        end
      end

      S_WP1: begin
        ptr_nxt   = ph_rd;
        phase_nxt = pltw_pkg::PH_PROG;
        state_nxt = S_WTOP;
      end

      S_WSCAN: begin
        if (p_r[LW-1]) begin
          if (phase_r == pltw_pkg::PH_PROG) begin
            rec_ra    = node_r;
            state_nxt = S_WG1;
          end else if (sp_r == '0) begin
            active_nxt = 1'b0;
            st_nxt     = pltw_pkg::ST_FINISH;
            state_nxt  = S_DONE;
          end else begin
            stk_ra    = adr(sp_r - CW'(1));
            state_nxt = S_WPOP;
          end
        end else if (!in_range(p_r, n_w) || (steps_r >= n_w)) begin
          // link out of range or a cyclic list
          active_nxt = 1'b0;
          st_nxt     = pltw_pkg::ST_ABORT;
          state_nxt  = S_DONE;
        end else begin
          steps_nxt = steps_r + CW'(1);
          pn_ra     = adr(p_r);
          rec_ra    = adr(p_r);
          vis_ra    = adr(p_r);
          state_nxt = S_WSCAN2;
        end
      end

      S_WSCAN2: begin
        if (vis_rd != epoch_r) begin
          if (sp_r + CW'(1) >= n_w) begin
            active_nxt = 1'b0;
            st_nxt     = pltw_pkg::ST_ABORT;
            state_nxt  = S_DONE;
          end else begin
            // save the resume point and descend into the unvisited entry
            stk_we    = 1'b1;
            stk_wa    = adr(sp_r);
            stk_wd    = {node_r, phase_r, nx_w};
            node_nxt  = adr(p_r);
            phase_nxt = pltw_pkg::PH_VISIT;
            ptr_nxt   = pltw_pkg::LINK_NONE;
            sp_nxt    = sp_r + CW'(1);
            state_nxt = S_WTOP;
          end
        end else begin
          p_nxt     = nx_w;
          state_nxt = S_WSCAN;
        end
      end

      S_WG1: begin
        g_nxt     = rec_rd.ghead;
        phase_nxt = pltw_pkg::PH_GROUP;
        ptr_nxt   = pltw_pkg::LINK_NONE;
        if (rec_rd.ghead[LW-1]) begin
          state_nxt = S_WTOP;
        end else if (!in_range(rec_rd.ghead, n_w)) begin
          active_nxt = 1'b0;
          st_nxt     = pltw_pkg::ST_ABORT;
          state_nxt  = S_DONE;
        end else begin
          gd_ra     = adr(rec_rd.ghead);
          state_nxt = S_WG2;
        end
      end

      S_WG2: begin
        // walk each group once per clear
        if (gd_rd != epoch_r) begin
          gd_we   = 1'b1;
          gd_wa   = adr(g_r);
          gd_wd   = epoch_r;
          ptr_nxt = g_r;
        end
        state_nxt = S_WTOP;
      end

      S_WPOP: begin
        node_nxt  = stk_rd[FR_W-1 -: AW];
        phase_nxt = pltw_pkg::phase_t'(stk_rd[LW +: 2]);
        ptr_nxt   = stk_rd[LW-1:0];
        sp_nxt    = sp_r - CW'(1);
        state_nxt = S_WTOP;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      halo_count_r <= pltw_pkg::HALO_COUNT_RST;
      epoch_r      <= EW'(1);
      sweep_all_r  <= 1'b1;
      sweep_clr_r  <= 1'b0;
      sw_r         <= '0;
      active_r     <= 1'b0;
      sp_r         <= '0;
      vc_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      sweep_all_r  <= sweep_all_nxt;
      sweep_clr_r  <= sweep_clr_nxt;
      sw_r         <= sw_nxt;
      active_r     <= active_nxt;
      sp_r         <= sp_nxt;
      vc_r         <= vc_nxt;
      if (cfg_we) begin
        halo_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    desc_r   <= desc_nxt;
    size_r   <= size_nxt;
    gfirst_r <= gfirst_nxt;
    gnext_r  <= gnext_nxt;
    h_r      <= h_nxt;
    d_r      <= d_nxt;
    g_r      <= g_nxt;
    p_r      <= p_nxt;
    steps_r  <= steps_nxt;
    node_r   <= node_nxt;
    phase_r  <= phase_nxt;
    ptr_r    <= ptr_nxt;
    st_r     <= st_nxt;
    vidx_r   <= vidx_nxt;
    vnum_r   <= vnum_nxt;
  end

  // record table: descendant, size, group head, group link
  pltw_ram #(.WIDTH(RECW), .DEPTH(MAX_HALOS)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(rec_ra),
    .rdata(rec_rd_raw)
  );

  pltw_ram #(.WIDTH(LW), .DEPTH(MAX_HALOS)) u_pnext_ram (
    .clk(clk), .we(pn_we), .waddr(pn_wa), .wdata(pn_wd), .raddr(pn_ra), .rdata(pn_rd)
  );

  pltw_ram #(.WIDTH(LW), .DEPTH(MAX_HALOS)) u_phead_ram (
    .clk(clk), .we(ph_we), .waddr(ph_wa), .wdata(ph_wd), .raddr(ph_ra), .rdata(ph_rd)
  );

  pltw_ram #(.WIDTH(EW), .DEPTH(MAX_HALOS)) u_vis_ram (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );

  pltw_ram #(.WIDTH(EW), .DEPTH(MAX_HALOS)) u_gd_ram (
    .clk(clk), .we(gd_we), .waddr(gd_wa), .wdata(gd_wd), .raddr(gd_ra), .rdata(gd_rd)
  );

  // walk stack frames below the top: entry, phase, resume pointer
  pltw_ram #(.WIDTH(FR_W), .DEPTH(MAX_HALOS)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  assign res_w.status = st_r;
  assign res_w.vidx   = vidx_r;
  assign res_w.vnum   = vnum_r;
  assign res_w.tsize  = vc_r;

  pltw_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (state_r == S_DONE),
    .load_data  (res_w),
    .load_ready (res_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (res_q)
  );

  assign out_status        = res_q.status;
  assign out_visited_index = res_q.vidx;
  assign out_visit_number  = res_q.vnum;
  assign out_tree_size     = res_q.tsize;

endmodule

FILE: rtl/core/pltw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pltw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/pltw_out_buf.sv
// Result output register: holds one result transaction until the sink takes it.
// Depends on pltw_pkg for the result type.
module pltw_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_valid,
  input  pltw_pkg::res_t  load_data,
  output logic            load_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output pltw_pkg::res_t  out_data
);

  logic           valid_r;
  pltw_pkg::res_t data_r;

  assign load_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_valid && load_ready) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/core/pltw_checker.sv
// Port-level checks for the progenitor link and tree walk block, bound to its top level.
// Depends on pltw_pkg for status codes.
module pltw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [2:0]                 out_status,
  input logic [pltw_pkg::IDX_W-1:0] out_visited_index,
  input logic [pltw_pkg::IDX_W-1:0] out_visit_number,
  input logic [pltw_pkg::CNT_W-1:0] out_tree_size
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_tree_size))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending input");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r < 2'd2)
    else $error("more than two transactions in flight");

  a_visit_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pltw_pkg::ST_VISIT
      |-> out_visit_number == out_tree_size[pltw_pkg::IDX_W-1:0] - 10'd1)
    else $error("visit number does not match tree size");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pltw_pkg::ST_DONE || out_status == pltw_pkg::ST_DESC_DROP ||
                  out_status == pltw_pkg::ST_HEAD_SKIP || out_status == pltw_pkg::ST_ROOT_SKIP ||
                  out_status == pltw_pkg::ST_FINISH)
      |-> out_visited_index == '0 && out_visit_number == '0)
    else $error("visit fields set on a non-visit result");

endmodule

bind progenitor_link_and_tree_walk pltw_checker u_pltw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_visited_index (out_visited_index),
  .out_visit_number  (out_visit_number),
  .out_tree_size     (out_tree_size)
);

FILE: sim/progenitor_link_and_tree_walk_test.sv
// Self-checking testbench for progenitor_link_and_tree_walk: loads, mark clears and tree walks.
// Depends on pltw_pkg and the block; its predictor tracks the halo table and the walk stack.
`timescale 1ns / 1ps

module progenitor_link_and_tree_walk_test;

  localparam int TBL        = 1024;
  localparam int QUIET_MAX  = 200000;

  typedef struct {
    pltw_pkg::mode_t    mode;
    logic [9:0]         idx;
    logic signed [10:0] desc;
    logic [30:0]        pc;
    logic signed [10:0] gfirst;
    logic signed [10:0] gnext;
  } halo_txn_t;

  typedef struct {
    pltw_pkg::status_t st;
    logic [9:0]        vidx;
    logic [9:0]        vnum;
    logic [10:0]       tsize;
  } walk_res_t;

  typedef struct {
    int               node;
    pltw_pkg::phase_t ph;
    int               ptr;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = '0;
  logic [9:0]         in_halo_index = '0;
  logic signed [10:0] in_descendant = '0;
  logic [30:0]        in_particle_count = '0;
  logic signed [10:0] in_group_first = '0;
  logic signed [10:0] in_group_next = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [9:0]         out_visited_index;
  logic [9:0]         out_visit_number;
  logic [10:0]        out_tree_size;
  logic               cfg_we = 1'b0;
  logic [10:0]        cfg_wdata = '0;

  // Predictor state: a shadow of the halo table, the marks and the walk stack.
  logic signed [10:0] desc_tab [TBL];
  logic [30:0]        size_tab [TBL];
  logic signed [10:0] prog_head [TBL];
  logic signed [10:0] prog_next [TBL];
  logic signed [10:0] grp_head [TBL];
  logic signed [10:0] grp_link [TBL];
  bit                 visited [TBL];
  bit                 grp_done [TBL];
  frame_t             walk_stk [TBL];
  int                 stk_top;
  int                 visit_cnt;
  int                 n_act;

  halo_txn_t pending_q [$];
  walk_res_t expected_q [$];
  int        halo_set [$];   // entries loaded in the current phase, the only safe link targets

  int send_idle_pct = 25;
  int stall_pct     = 68;
  int errors        = 0;
  int results_seen  = 0;
  int visits_seen   = 0;
  int aborts_seen   = 0;
  int hold_left     = 0;
  bit pressure_done = 1'b0;
  int quiet_cycles  = 0;

  progenitor_link_and_tree_walk u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_halo_index     (in_halo_index),
    .in_descendant     (in_descendant),
    .in_particle_count (in_particle_count),
    .in_group_first    (in_group_first),
    .in_group_next     (in_group_next),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_visited_index (out_visited_index),
    .out_visit_number  (out_visit_number),
    .out_tree_size     (out_tree_size),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic void push_frame(int slot, int node);
    stk_top = slot;
    walk_stk[slot].node = node;
    walk_stk[slot].ph = pltw_pkg::PH_VISIT;
    walk_stk[slot].ptr = -1;
  endfunction

  // Run the walk until the next preorder visit, the end of the tree or an error.
  function automatic pltw_pkg::status_t walk_next(output int vi, output int vn);
    int t, i, p, steps, nx, d, g;
    bit prog, pushed;
    vi = 0;
    vn = 0;
    while (stk_top >= 0) begin
      if (stk_top >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
      t = stk_top;
      i = walk_stk[t].node;
      case (walk_stk[t].ph)
        pltw_pkg::PH_VISIT: begin
          if (visit_cnt >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
          visited[i] = 1'b1;
          vi = i;
          vn = visit_cnt;
          visit_cnt++;
          walk_stk[t].ph = pltw_pkg::PH_PROG_INIT;
          d = desc_tab[i];
          if (d >= 0) begin
            if (d >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
            if (!visited[d]) begin
              if (t + 1 >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
              push_frame(t + 1, d);
            end
          end
          return pltw_pkg::ST_VISIT;
        end
        pltw_pkg::PH_PROG_INIT: begin
          walk_stk[t].ph = pltw_pkg::PH_PROG;
          walk_stk[t].ptr = prog_head[i];
        end
        default: begin
          prog = (walk_stk[t].ph == pltw_pkg::PH_PROG);
          pushed = 1'b0;
          p = walk_stk[t].ptr;
          steps = 0;
          while (p >= 0 && !pushed) begin
            steps++;
            if (p >= n_act || steps > n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
            nx = prog ? prog_next[p] : grp_link[p];
            if (!visited[p]) begin
              if (t + 1 >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
              walk_stk[t].ptr = nx;
              push_frame(t + 1, p);
              pushed = 1'b1;
            end else begin
              p = nx;
            end
          end
          if (!pushed) begin
            if (prog) begin
              g = grp_head[i];
              walk_stk[t].ph = pltw_pkg::PH_GROUP;
              walk_stk[t].ptr = -1;
              if (g >= 0) begin
                if (g >= n_act) begin stk_top = -1; return pltw_pkg::ST_ABORT; end
                if (!grp_done[g]) begin
                  grp_done[g] = 1'b1;
                  walk_stk[t].ptr = g;
                end
              end
            end else begin
              stk_top = t - 1;
            end
          end
        end
      endcase
    end
    return pltw_pkg::ST_FINISH;
  endfunction

  function automatic walk_res_t predict(halo_txn_t it);
    walk_res_t r;
    int idx, d, h, vi, vn;
    r.st = pltw_pkg::ST_DONE;
    vi = 0;
    vn = 0;
    idx = it.idx;
    case (it.mode)
      pltw_pkg::MODE_LOAD: begin
        if (idx < n_act) begin
          d = it.desc;
          size_tab[idx] = it.pc;
          grp_head[idx] = it.gfirst;
          grp_link[idx] = it.gnext;
          prog_next[idx] = -11'sd1;
          if (d >= n_act) begin
            desc_tab[idx] = -11'sd1;
            r.st = pltw_pkg::ST_DESC_DROP;
          end else if (d < 0) begin
            desc_tab[idx] = -11'sd1;
          end else begin
            h = prog_head[d];
            desc_tab[idx] = 11'(d);
            if (h < 0) begin
              prog_head[d] = 11'(idx);
            end else if (h >= n_act) begin
              r.st = pltw_pkg::ST_HEAD_SKIP;
            end else if (size_tab[idx] >= size_tab[h]) begin
              prog_next[idx] = 11'(h);
              prog_head[d] = 11'(idx);
            end else begin
              prog_next[idx] = prog_next[h];
              prog_next[h] = 11'(idx);
            end
          end
        end
      end
      pltw_pkg::MODE_CLEAR: begin
        visited = '{default: 1'b0};
        grp_done = '{default: 1'b0};
      end
      pltw_pkg::MODE_START: begin
        stk_top = -1;
        if (idx >= n_act || visited[idx] || grp_head[idx] < 0) begin
          r.st = pltw_pkg::ST_ROOT_SKIP;
        end else begin
          visit_cnt = 0;
          push_frame(0, idx);
        end
      end
      default: r.st = walk_next(vi, vn);
    endcase
    r.vidx = vi[9:0];
    r.vnum = vn[9:0];
    r.tsize = visit_cnt[10:0];
    return r;
  endfunction

  // Queue one transaction together with the result it must produce.
  function automatic pltw_pkg::status_t emit(halo_txn_t it);
    walk_res_t r;
    r = predict(it);
    expected_q.push_back(r);
    pending_q.push_back(it);
    return r.st;
  endfunction

  function automatic logic signed [10:0] pick_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 11'(halo_set[$urandom_range(0, halo_set.size() - 1)]);
    if (r < 75) return -11'sd1;
    if (r < 85) return 11'(-int'($urandom_range(1, 1024)));
    if (n_act < TBL) return 11'($urandom_range(n_act, 1023));
    return 11'(halo_set[$urandom_range(0, halo_set.size() - 1)]);
  endfunction

  function automatic logic [30:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 31'($urandom_range(0, 3));
    if (r < 40) return 31'h7FFF_FFFF;
    return 31'($urandom());
  endfunction

  function automatic halo_txn_t mk_txn(pltw_pkg::mode_t m, int idx, int d, logic [30:0] pc,
                                       int gf, int gn);
    halo_txn_t it;
    it.mode = m;
    it.idx = idx[9:0];
    it.desc = d[10:0];
    it.pc = pc;
    it.gfirst = gf[10:0];
    it.gnext = gn[10:0];
    return it;
  endfunction

  function automatic halo_txn_t rand_load(int idx, bit below_max);
    logic [30:0] pc;
    pc = pick_size();
    if (below_max && pc == 31'h7FFF_FFFF) pc = 31'h7FFF_FFFE;
    return mk_txn(pltw_pkg::MODE_LOAD, idx, pick_link(), pc, pick_link(), pick_link());
  endfunction

  // Start at a root and advance until the walk ends, then poke an idle walk now and then.
  function automatic int walk_tree(int root);
    pltw_pkg::status_t st;
    int cnt;
    cnt = 1;
    st = emit(mk_txn(pltw_pkg::MODE_START, root, $urandom_range(0, 2047) - 1024,
                     31'($urandom()), $urandom_range(0, 2047) - 1024,
                     $urandom_range(0, 2047) - 1024));
    if (st == pltw_pkg::ST_ROOT_SKIP) return cnt;
    do begin
      // drop the walk halfway now and then by starting a fresh one
      if ($urandom_range(0, 99) < 2) return cnt;
      st = emit(mk_txn(pltw_pkg::MODE_ADVANCE, $urandom_range(0, 1023),
                       $urandom_range(0, 2047) - 1024, 31'($urandom()), -1, -1));
      cnt++;
    end while (st == pltw_pkg::ST_VISIT);
    repeat ($urandom_range(0, 2)) begin
      void'(emit(mk_txn(pltw_pkg::MODE_ADVANCE, $urandom_range(0, 1023), -1, 31'd0, -1, -1)));
      cnt++;
    end
    return cnt;
  endfunction

  task automatic wait_idle();
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(int n, int budget, int ph_num);
    bit taken [TBL];
    int k, cnt, idx, r;
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    n_act = n;
    send_idle_pct = (ph_num < 2) ? 25 : (ph_num < 4) ? 68 : 0;
    stall_pct     = (ph_num < 2) ? 68 : (ph_num < 4) ? 25 : 0;

    // pick this phase's entries; all are loaded before any walk so links stay defined
    taken = '{default: 1'b0};
    halo_set.delete();
    if (ph_num == 0) begin
      halo_set = '{0, 5, 6, 1023};
      foreach (halo_set[j]) taken[halo_set[j]] = 1'b1;
    end
    if (ph_num == 1) begin
      halo_set.push_back(1);
      taken[1] = 1'b1;
    end
    k = (n < 40) ? n : $urandom_range(12, 40);
    while (halo_set.size() < k) begin
      idx = $urandom_range(0, n - 1);
      if (!taken[idx]) begin
        taken[idx] = 1'b1;
        halo_set.push_back(idx);
      end
    end
    halo_set.sort();
    cnt = 0;

    if (ph_num == 0) begin
      // directed: a small tree with a tie on size and a group list, then walks around a clear
      void'(emit(mk_txn(pltw_pkg::MODE_LOAD, 0, -1, 31'h7FFF_FFFF, 0, -1)));
      void'(emit(mk_txn(pltw_pkg::MODE_LOAD, 5, 0, 31'd0, 0, 6)));
      void'(emit(mk_txn(pltw_pkg::MODE_LOAD, 6, 0, 31'd0, 0, 0)));
      foreach (halo_set[j])
        if (!(halo_set[j] inside {0, 5, 6, 1023})) void'(emit(rand_load(halo_set[j], 1'b1)));
      // last load makes 1023 the head of entry 0's progenitor list
      void'(emit(mk_txn(pltw_pkg::MODE_LOAD, 1023, 0, 31'h7FFF_FFFF, 1023, -1)));
      cnt += halo_set.size();
      cnt += walk_tree(0);
      cnt += walk_tree(0);   // root already visited
      void'(emit(mk_txn(pltw_pkg::MODE_CLEAR, 0, 0, 31'd0, 0, 0)));
      cnt++;
      cnt += walk_tree(1023);
    end else begin
      // head of entry 0 is 1023, now out of range after the count drops
      if (ph_num == 1) void'(emit(mk_txn(pltw_pkg::MODE_LOAD, 1, 0, 31'd7, 1, -1)));
      foreach (halo_set[j])
        if (!(ph_num == 1 && halo_set[j] == 1)) void'(emit(rand_load(halo_set[j], 1'b0)));
      cnt += halo_set.size();
    end

    while (cnt < budget) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        void'(emit(mk_txn(pltw_pkg::MODE_CLEAR, $urandom_range(0, 1023),
                          $urandom_range(0, 2047) - 1024, 31'($urandom()),
                          $urandom_range(0, 2047) - 1024,
                          $urandom_range(0, 2047) - 1024)));
        cnt++;
      end else if (r < 33) begin
        // reload an entry, occasionally one that is out of range
        if (n < TBL && $urandom_range(0, 3) == 0)
          void'(emit(rand_load($urandom_range(n, 1023), 1'b1)));
        else
          void'(emit(rand_load(halo_set[$urandom_range(0, halo_set.size() - 1)], 1'b1)));
        cnt++;
      end else if (r < 38 && n < TBL) begin
        cnt += walk_tree($urandom_range(n, 1023));
      end else begin
        cnt += walk_tree(halo_set[$urandom_range(0, halo_set.size() - 1)]);
      end
    end
  endtask

  // Input driver: advance to the next pending transaction, hold while stalled.
  always @(posedge clk) begin
    halo_txn_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= it.mode;
        in_halo_index <= it.idx;
        in_descendant <= it.desc;
        in_particle_count <= it.pc;
        in_group_first <= it.gfirst;
        in_group_next <= it.gnext;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    walk_res_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d index %0d number %0d size %0d", $time,
                   out_status, out_visited_index, out_visit_number, out_tree_size);
        end else begin
          e = expected_q.pop_front();
          if (e.st == pltw_pkg::ST_VISIT) visits_seen++;
          if (e.st == pltw_pkg::ST_ABORT) aborts_seen++;
          if (out_status !== e.st || out_visited_index !== e.vidx ||
              out_visit_number !== e.vnum || out_tree_size !== e.tsize) begin
            errors++;
            $display("%0t: expected status %0d index %0d number %0d size %0d, got %0d %0d %0d %0d",
                     $time, e.st, e.vidx, e.vnum, e.tsize, out_status, out_visited_index,
                     out_visit_number, out_tree_size);
          end
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (!pressure_done && results_seen >= 40) begin
        pressure_done = 1'b1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: drop the run if nothing moves while work is outstanding.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_q.size() == 0 && expected_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("progenitor_link_and_tree_walk: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // shadow state after reset; never-loaded entries read as zero
    desc_tab = '{default: '0};
    size_tab = '{default: '0};
    prog_next = '{default: '0};
    grp_head = '{default: '0};
    grp_link = '{default: '0};
    prog_head = '{default: -11'sd1};
    visited = '{default: 1'b0};
    grp_done = '{default: 1'b0};
    stk_top = -1;
    visit_cnt = 0;
    n_act = TBL;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // halo count only shrinks, so a link out of range stays out of range
    run_phase(1024, 170, 0);
    run_phase(1023, 170, 1);
    run_phase(300, 170, 2);
    run_phase(64, 170, 3);
    run_phase(17, 170, 4);
    run_phase(1, 150, 5);

    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Checked %0d results (%0d visits, %0d aborted walks) over halo counts 1024 to 1,",
             results_seen, visits_seen, aborts_seen);
    $display("with loads, mark clears, walk starts and advances under random idling and stalls.");
    if (errors == 0) begin
      $display("progenitor_link_and_tree_walk: match");
    end else begin
      $display("progenitor_link_and_tree_walk: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pltw_pkg.sv
rtl/core/pltw_ram.sv
rtl/core/pltw_out_buf.sv
rtl/core/progenitor_link_and_tree_walk.sv
rtl/core/pltw_checker.sv
sim/progenitor_link_and_tree_walk_test.sv
